// ===== sv/u8u16_pkg.sv =====
// Shared types, constants and the code point to code unit function of the UTF-8 to UTF-16 block.
package u8u16_pkg;

  localparam int unsigned PointW = 21;
  localparam int unsigned UnitW  = 16;

  localparam logic [7:0]        ContMask  = 8'hC0;
  localparam logic [7:0]        ContTag   = 8'h80;
  localparam logic [7:0]        Lead2Mask = 8'hE0;
  localparam logic [7:0]        Lead2Tag  = 8'hC0;
  localparam logic [7:0]        Lead3Mask = 8'hF0;
  localparam logic [7:0]        Lead3Tag  = 8'hE0;
  localparam logic [7:0]        Lead4Mask = 8'hF8;
  localparam logic [7:0]        Lead4Tag  = 8'hF0;
  localparam logic [PointW-1:0] BmpMax    = 21'h00FFFF;
  localparam logic [PointW-1:0] SuppBase  = 21'h010000;
  localparam logic [UnitW-1:0]  HiSurr    = 16'hD800;
  localparam logic [UnitW-1:0]  LoSurr    = 16'hDC00;

  // Pending result: one unit, or a surrogate pair (u0 high half, u1 low half).
  typedef struct packed {
    logic             pair;
    logic [UnitW-1:0] u0;
    logic [UnitW-1:0] u1;
  } unit_slot_t;

  function automatic unit_slot_t point_to_units(input logic [PointW-1:0] cp);
    unit_slot_t        s;
    logic [PointW-1:0] off;
    off     = cp - SuppBase;
    s.pair  = (cp > BmpMax);
    s.u0    = s.pair ? (HiSurr + {5'd0, off[PointW-1:10]}) : cp[UnitW-1:0];
    s.u1    = LoSurr + {6'd0, cp[9:0]};
    return s;
  endfunction

endpackage

// ===== sv/utf8_to_utf16be_transcoder.sv =====
// UTF-8 byte stream to UTF-16 code unit stream transcoder, top level.
//
//  channel | ports                                          | word
//  --------+------------------------------------------------+-------------------------------
//  in      | in_valid, in_stall, in_byte, in_end_of_string  | one UTF-8 byte, end-of-string
//  out     | out_valid, out_stall, out_code_unit,           | one UTF-16 unit, last-of-point
//          | out_run_last                                   |
//
// One byte is taken per cycle while in_stall is low; the decode runs in the
// accept cycle into a two-slot result buffer. A surrogate pair occupies its
// slot until both its units are delivered, so in_stall rises only when both
// slots hold undelivered results. Synchronous active-low reset clears the
// decoder state and empties the buffer. out_stall holds the current unit;
// the input keeps flowing until the spare slot is taken.
module utf8_to_utf16be_transcoder (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_byte,
  input  logic                      in_end_of_string,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [u8u16_pkg::UnitW-1:0] out_code_unit,
  output logic                      out_run_last
);
  import u8u16_pkg::*;

  logic [PointW-1:0] point_r, point_nxt;
  logic [1:0]        expect_r, expect_nxt;
  logic              a_vld_r, a_vld_nxt;
  logic              b_vld_r, b_vld_nxt;
  logic              a_ph_r, a_ph_nxt;
  unit_slot_t        a_r, a_nxt;
  unit_slot_t        b_r, b_nxt;

  logic              in_fire, out_fire, a_done, a_free;
  logic              done;
  logic [PointW-1:0] cp;
  unit_slot_t        new_slot;

  assign in_stall      = b_vld_r;
  assign in_fire       = in_valid & ~in_stall;
  assign out_valid     = a_vld_r;
  assign out_code_unit = a_ph_r ? a_r.u1 : a_r.u0;
  assign out_run_last  = ~a_r.pair | a_ph_r;
  assign out_fire      = a_vld_r & ~out_stall;
  assign a_done        = out_fire & (~a_r.pair | a_ph_r);
  assign a_free        = ~a_vld_r | a_done;

  // Byte decode.
  always_comb begin
    done       = 1'b0;
    cp         = '0;
    point_nxt  = point_r;
    expect_nxt = expect_r;
    if (in_fire) begin
      if (expect_r != 2'd0 && (in_byte & ContMask) == ContTag) begin
        point_nxt  = {point_r[PointW-7:0], in_byte[5:0]};
        expect_nxt = expect_r - 2'd1;
        if (expect_r == 2'd1) begin
          done      = 1'b1;
          cp        = {point_r[PointW-7:0], in_byte[5:0]};
          point_nxt = '0;
        end
      end else begin
        // broken sequence drops the partial point; byte starts afresh
        point_nxt  = '0;
        expect_nxt = 2'd0;
        if (in_byte[7] == 1'b0) begin
          done = 1'b1;
          cp   = {13'd0, in_byte};
        end else if ((in_byte & Lead2Mask) == Lead2Tag) begin
          point_nxt  = {16'd0, in_byte[4:0]};
          expect_nxt = 2'd1;
        end else if ((in_byte & Lead3Mask) == Lead3Tag) begin
          point_nxt  = {17'd0, in_byte[3:0]};
          expect_nxt = 2'd2;
        end else if ((in_byte & Lead4Mask) == Lead4Tag) begin
          point_nxt  = {18'd0, in_byte[2:0]};
          expect_nxt = 2'd3;
        end
      end
      if (in_end_of_string) begin
        point_nxt  = '0;
        expect_nxt = 2'd0;
      end
    end
  end

  assign new_slot = point_to_units(cp);

  // Result buffer: slot a drives the port, slot b catches a word while a waits.
  always_comb begin
    a_nxt     = a_r;
    b_nxt     = b_r;
    a_vld_nxt = a_vld_r;
    b_vld_nxt = b_vld_r;
    a_ph_nxt  = a_ph_r;
    if (a_free) begin
      a_ph_nxt = 1'b0;
      if (b_vld_r) begin
        a_nxt     = b_r;
        a_vld_nxt = 1'b1;
        b_vld_nxt = 1'b0;
      end else begin
        a_nxt     = new_slot;
        a_vld_nxt = done;
      end
    end else begin
      if (out_fire && a_r.pair && !a_ph_r) begin
        a_ph_nxt = 1'b1;
      end
      if (!b_vld_r) begin
        b_nxt     = new_slot;
        b_vld_nxt = done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_r  <= '0;
      expect_r <= 2'd0;
      a_vld_r  <= 1'b0;
      b_vld_r  <= 1'b0;
      a_ph_r   <= 1'b0;
    end else begin
      point_r  <= point_nxt;
      expect_r <= expect_nxt;
      a_vld_r  <= a_vld_nxt;
      b_vld_r  <= b_vld_nxt;
      a_ph_r   <= a_ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

endmodule

// ===== tb/utf16_unit_checker.sv =====
// Checker for the UTF-8 to UTF-16 transcoder: predicts code units per accepted byte and compares.
`timescale 1ns / 1ps

module utf16_unit_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [7:0]          in_byte,
  input  logic                in_end_of_string,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [u8u16_pkg::UnitW-1:0] out_code_unit,
  input  logic                out_run_last,
  output int                  mismatches,
  output int                  units_due,
  output int                  units_seen
);
  import u8u16_pkg::*;

  typedef struct packed {
    logic [UnitW-1:0] unit;
    logic             is_last;
  } unit_exp_t;

  unit_exp_t         units_q[$];
  unit_exp_t         want;
  logic [PointW-1:0] acc_point;
  logic [1:0]        conts_due;
  int                n_bad;
  int                n_seen;

  initial begin
    acc_point  = '0;
    conts_due  = '0;
    n_bad      = 0;
    n_seen     = 0;
    mismatches = 0;
    units_due  = 0;
    units_seen = 0;
  end

  task automatic queue_unit(input logic [UnitW-1:0] u, input logic fin);
    unit_exp_t e;
    e.unit    = u;
    e.is_last = fin;
    units_q.push_back(e);
  endtask

  // BMP points go out as one unit, anything larger as a surrogate pair (mod 2^16)
  task automatic queue_point(input logic [PointW-1:0] cp);
    logic [PointW-1:0] off;
    if (cp <= BmpMax) begin
      queue_unit(cp[UnitW-1:0], 1'b1);
    end else begin
      off = cp - SuppBase;
      queue_unit(HiSurr + {5'd0, off[PointW-1:10]}, 1'b0);
      queue_unit(LoSurr + {6'd0, off[9:0]}, 1'b1);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eos);
    logic              done;
    logic [PointW-1:0] cp;
    done = 1'b0;
    cp   = '0;
    if (conts_due != 2'd0 && (b & ContMask) == ContTag) begin
      acc_point = {acc_point[PointW-7:0], b[5:0]};
      conts_due = conts_due - 2'd1;
      if (conts_due == 2'd0) begin
        done      = 1'b1;
        cp        = acc_point;
        acc_point = '0;
      end
    end else begin
      // anything but a continuation restarts decoding at this byte
      conts_due = 2'd0;
      acc_point = '0;
      if (!b[7]) begin
        done = 1'b1;
        cp   = {13'd0, b};
      end else if ((b & Lead2Mask) == Lead2Tag) begin
        acc_point = {16'd0, b[4:0]};
        conts_due = 2'd1;
      end else if ((b & Lead3Mask) == Lead3Tag) begin
        acc_point = {17'd0, b[3:0]};
        conts_due = 2'd2;
      end else if ((b & Lead4Mask) == Lead4Tag) begin
        acc_point = {18'd0, b[2:0]};
        conts_due = 2'd3;
      end
    end
    if (done) queue_point(cp);
    if (eos) begin
      acc_point = '0;
      conts_due = 2'd0;
    end
  endtask

  // input word is predicted before the output word is checked, so a same-edge
  // pass-through would still line up
  always @(posedge clk) begin
    if (!rst_n) begin
      acc_point = '0;
      conts_due = '0;
      units_q.delete();
    end else begin
      if (in_valid && !in_stall) decode_byte(in_byte, in_end_of_string);
      if (out_valid && !out_stall) begin
        n_seen++;
        if (units_q.size() == 0) begin
          $error("code_unit: expected none, got %h (run_last %b)", out_code_unit,
                 out_run_last);
          n_bad++;
        end else begin
          want = units_q.pop_front();
          if (out_code_unit !== want.unit) begin
            $error("code_unit: expected %h, got %h", want.unit, out_code_unit);
            n_bad++;
          end
          if (out_run_last !== want.is_last) begin
            $error("run_last: expected %b, got %b", want.is_last, out_run_last);
            n_bad++;
          end
        end
      end
    end
    mismatches <= n_bad;
    units_due  <= units_q.size();
    units_seen <= n_seen;
  end

endmodule

// ===== tb/tb_utf8_to_utf16be_transcoder.sv =====
// Testbench top for the UTF-8 to UTF-16 transcoder: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_utf8_to_utf16be_transcoder;
  import u8u16_pkg::*;

  localparam int CycleLimit = 400000;

  logic             clk              = 1'b0;
  logic             rst_n            = 1'b0;
  logic             in_valid         = 1'b0;
  logic [7:0]       in_byte          = 8'h00;
  logic             in_end_of_string = 1'b0;
  logic             out_stall        = 1'b0;
  wire              in_stall;
  wire              out_valid;
  wire  [UnitW-1:0] out_code_unit;
  wire              out_run_last;

  int mismatches;
  int units_due;
  int units_seen;
  int bytes_sent = 0;
  int eos_sent   = 0;
  int cycles     = 0;
  bit calm       = 1'b0;

  always #5 clk = ~clk;

  utf8_to_utf16be_transcoder uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_end_of_string(in_end_of_string),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_unit   (out_code_unit),
    .out_run_last    (out_run_last)
  );

  utf16_unit_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_end_of_string(in_end_of_string),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_unit   (out_code_unit),
    .out_run_last    (out_run_last),
    .mismatches      (mismatches),
    .units_due       (units_due),
    .units_seen      (units_seen)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stall before each word, none while calm
  initial begin : result_stall
    int hold;
    wait (rst_n);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 17);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_byte          <= b;
    in_end_of_string <= eos;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (eos) eos_sent++;
  endtask

  // hold off the sender until every predicted unit has been delivered
  task automatic drain_units();
    in_valid <= 1'b0;
    do @(posedge clk); while (units_due != 0);
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  function automatic logic eos_draw();
    return $urandom_range(0, 15) == 0;
  endfunction

  // mostly well-formed sequences; some truncated ones and raw noise
  task automatic send_run();
    int         kind;
    int         len;
    int         conts;
    logic [7:0] lead;
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      send_byte(8'($urandom_range(0, 255)), eos_draw());
    end else begin
      len = $urandom_range(1, 4);
      case (len)
        1:       lead = 8'($urandom_range(0, 127));
        2:       lead = 8'hC0 | 8'($urandom_range(0, 31));
        3:       lead = 8'hE0 | 8'($urandom_range(0, 15));
        default: lead = 8'hF0 | 8'($urandom_range(0, 7));
      endcase
      conts = len - 1;
      if (kind >= 80 && len > 1) conts = $urandom_range(0, len - 2);
      send_byte(lead, eos_draw());
      repeat (conts) send_byte(cont_byte(), eos_draw());
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero byte, top ASCII closing a string
    send_byte(8'h00, 1'b0); send_byte(8'h7F, 1'b1);
    // two-byte point whose last byte ends the string
    send_byte(8'hC2, 1'b0); send_byte(8'hA9, 1'b1);
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'hAC, 1'b0);
    // surrogate pair, then the largest 21-bit point
    send_byte(8'hF0, 1'b0); send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
    // overlong four-byte zero: single unit
    send_byte(8'hF0, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b0);
    // stray continuation, invalid lead
    send_byte(8'h80, 1'b0); send_byte(8'hF8, 1'b0);
    // broken sequence restarts at the ASCII byte
    send_byte(8'hE2, 1'b0); send_byte(8'h41, 1'b0);
    // string end drops the open lead; its continuation is then stray
    send_byte(8'hC3, 1'b1); send_byte(8'hA9, 1'b0);
    drain_units();

    while (bytes_sent < 230) send_run();
    drain_units();

    calm = 1'b1;
    while (bytes_sent < 400) send_run();
    drain_units();
    calm = 1'b0;

    while (bytes_sent < 550) send_run();
    drain_units();
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes (%0d closing a string), checked %0d code units.",
             bytes_sent, eos_sent, units_seen);
    $display("Mix: 1-4 byte sequences, surrogate pairs, stray/invalid/broken bytes, idle and "
             , "back-to-back phases.");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
